### hw/rtl/gmdv_pkg.sv
package gmdv_pkg;

    localparam int FIELD_W              = 7;
    localparam int MAX_VERTICES_DEFAULT = 64;
    localparam logic [FIELD_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    typedef struct packed {
        logic add_en;
        logic clear_en;
        logic shift_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear_en;
        logic sample_en;
    } rank_ctrl_t;

endpackage

### hw/rtl/gmdv_cell.sv
module gmdv_cell
    import gmdv_pkg::*;
#(
    parameter int NV         = MAX_VERTICES_DEFAULT,
    parameter int CELL_INDEX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [$clog2(NV)-1:0] a_idx,
    input  logic [$clog2(NV)-1:0] b_idx,
    input  logic [NV-1:0]         row_in,
    output logic [NV-1:0]         row_out
);

    localparam int IW = $clog2(NV);

    logic [NV-1:0] row_reg;
    logic [NV-1:0] row_next;
    logic [NV-1:0] hit;
    logic          own_a;
    logic          own_b;

    assign own_a = (a_idx == IW'(CELL_INDEX));
    assign own_b = (b_idx == IW'(CELL_INDEX));

    always_comb
    begin
        for (int c = 0; c < NV; c++)
        begin
            hit[c] = (own_a && (b_idx == IW'(c))) || (own_b && (a_idx == IW'(c)));
        end
    end

    always_comb
    begin
        row_next = row_reg;
        if (ctrl.clear_en)
        begin
            row_next = '0;
        end
        else if (ctrl.shift_en)
        begin
            row_next = row_in;
        end
        else if (ctrl.add_en)
        begin
            row_next = row_reg | hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row_out = row_reg;

endmodule

### hw/rtl/gmdv_rank.sv
module gmdv_rank
    import gmdv_pkg::*;
#(
    parameter int NV = MAX_VERTICES_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rank_ctrl_t              ctrl,
    input  logic [NV-1:0]           row,
    input  logic [NV-1:0]           col_mask,
    input  logic [$clog2(NV)-1:0]   row_idx,
    output logic [$clog2(NV+1)-1:0] best_vertex,
    output logic [$clog2(NV+1)-1:0] best_degree
);

    localparam int IW = $clog2(NV);
    localparam int DW = $clog2(NV + 1);

    logic          ok_reg;
    logic [DW-1:0] deg_reg;
    logic [IW-1:0] idx_reg;
    logic [DW-1:0] best_deg_reg;
    logic [DW-1:0] best_deg_next;
    logic [DW-1:0] best_v_reg;
    logic [DW-1:0] best_v_next;

    // first stage: degree of the row at the head of the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= ctrl.sample_en;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg <= DW'($countones(row & col_mask));
        idx_reg <= row_idx;
    end

    // second stage: keep the first strictly greater degree
    always_comb
    begin
        best_deg_next = best_deg_reg;
        best_v_next   = best_v_reg;
        if (ctrl.clear_en)
        begin
            best_deg_next = '0;
            best_v_next   = '0;
        end
        else if (ok_reg && (deg_reg > best_deg_reg))
        begin
            best_deg_next = deg_reg;
            best_v_next   = DW'(idx_reg) + DW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_deg_reg <= '0;
            best_v_reg   <= '0;
        end
        else
        begin
            best_deg_reg <= best_deg_next;
            best_v_reg   <= best_v_next;
        end
    end

    assign best_vertex = best_v_reg;
    assign best_degree = best_deg_reg;

endmodule

### hw/rtl/graph_max_degree_vertex_unit.sv
// add-edge and clear items never raise busy
// a query raises busy through the scan, drain and done states; its result is taken in
// the done state, after the rows rotate one a cycle past one popcount unit
// the receiver cannot stall; the result is shown for exactly one cycle
// reset clears the whole matrix and sets vertex_count to 64
module graph_max_degree_vertex_unit
    import gmdv_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [FIELD_W-1:0] first_vertex,
    input  logic [FIELD_W-1:0] second_vertex,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] vertex_count,
    output logic               result_valid,
    output logic [FIELD_W-1:0] best_vertex,
    output logic [FIELD_W-1:0] best_degree
);

    localparam int NV = MAX_VERTICES;
    localparam int IW = $clog2(NV);
    localparam int DW = $clog2(NV + 1);
    localparam int UW = (DW > FIELD_W) ? DW : FIELD_W;

    state_t             state_reg;
    state_t             state_next;
    logic [IW-1:0]      cnt_reg;
    logic [IW-1:0]      cnt_next;
    logic [FIELD_W-1:0] vcount_reg;
    logic [UW-1:0]      vc_ext;
    logic [UW-1:0]      used;
    logic [NV-1:0]      col_mask;
    logic [UW-1:0]      a_ext;
    logic [UW-1:0]      b_ext;
    logic [IW-1:0]      a_idx;
    logic [IW-1:0]      b_idx;
    logic               a_ok;
    logic               b_ok;
    logic               accept;
    kind_t              kind_in;
    cell_ctrl_t         cell_ctrl;
    rank_ctrl_t         rank_ctrl;
    logic [NV-1:0]      rows [NV];
    logic [DW-1:0]      best_v_full;
    logic [DW-1:0]      best_d_full;

    assign kind_in = kind_t'(kind);
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;

    // configuration
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VERTEX_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vcount_reg <= vertex_count;
        end
    end

    assign vc_ext = UW'(vcount_reg);
    assign used   = (vc_ext > UW'(NV)) ? UW'(NV) : vc_ext;

    always_comb
    begin
        for (int c = 0; c < NV; c++)
        begin
            col_mask[c] = (UW'(c) < used);
        end
    end

    // edge endpoints
    assign a_ext = UW'(first_vertex);
    assign b_ext = UW'(second_vertex);
    assign a_ok  = (a_ext != '0) && (a_ext <= UW'(NV));
    assign b_ok  = (b_ext != '0) && (b_ext <= UW'(NV));
    assign a_idx = IW'(a_ext - UW'(1));
    assign b_idx = IW'(b_ext - UW'(1));

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        cell_ctrl           = '0;
        rank_ctrl           = '0;
        result_valid        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind_in)
                        KIND_ADD:
                        begin
                            cell_ctrl.add_en = a_ok && b_ok;
                        end
                        KIND_CLEAR:
                        begin
                            cell_ctrl.clear_en = 1'b1;
                        end
                        KIND_QUERY:
                        begin
                            rank_ctrl.clear_en = 1'b1;
                            cnt_next           = '0;
                            state_next         = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cell_ctrl.shift_en  = 1'b1;
                rank_ctrl.sample_en = (UW'(cnt_reg) < used);
                if (cnt_reg == IW'(NV - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                result_valid = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // row of cells, rotating towards cell zero during a query
    for (genvar i = 0; i < NV; i++)
    begin : g_cell
        gmdv_cell #(
            .NV         (NV),
            .CELL_INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .a_idx   (a_idx),
            .b_idx   (b_idx),
            .row_in  (rows[(i + 1) % NV]),
            .row_out (rows[i])
        );
    end

    gmdv_rank #(
        .NV (NV)
    ) u_rank (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (rank_ctrl),
        .row         (rows[0]),
        .col_mask    (col_mask),
        .row_idx     (cnt_reg),
        .best_vertex (best_v_full),
        .best_degree (best_d_full)
    );

    assign best_vertex = FIELD_W'(best_v_full);
    assign best_degree = FIELD_W'(best_d_full);

`ifndef SYNTHESIS
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_QUERY)) |=> busy)
        else $error("query did not raise busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_DRAIN))
        else $error("result strobe without a finished scan");

    a_best_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (best_v_full == '0) == (best_d_full == '0))
        else $error("best vertex and degree disagree on empty result");
`endif

endmodule
